FILE: sv/amq_pkg.sv
// ----------------------------------------------------------------------------
// amq_pkg
// Types and constants shared by the 16.16 affine matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

package amq_pkg;

  typedef enum logic [2:0] {
    K_CAT_MAT   = 3'd0,
    K_CAT_TRANS = 3'd1,
    K_XFORM     = 3'd2,
    K_IDENT     = 3'd3,
    K_INVERT    = 3'd4
  } kind_e;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL    = 10'b00_0000_0010,
    S_ADD    = 10'b00_0000_0100,
    S_COMMIT = 10'b00_0000_1000,
    S_DET1   = 10'b00_0001_0000,
    S_DET2   = 10'b00_0010_0000,
    S_DET3   = 10'b00_0100_0000,
    S_DIVS   = 10'b00_1000_0000,
    S_DIVW   = 10'b01_0000_0000,
    S_COPY   = 10'b10_0000_0000
  } state_e;

  // matrix entry slots
  localparam logic [2:0] IDX_A  = 3'd0;
  localparam logic [2:0] IDX_B  = 3'd1;
  localparam logic [2:0] IDX_C  = 3'd2;
  localparam logic [2:0] IDX_D  = 3'd3;
  localparam logic [2:0] IDX_TX = 3'd4;
  localparam logic [2:0] IDX_TY = 3'd5;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [47:0] RND_Q16 = 48'h0000_0000_8000;

endpackage

`default_nettype wire

FILE: sv/amq_div.sv
// ----------------------------------------------------------------------------
// amq_div
// Restoring divider, one quotient bit per cycle: ({num,32'b0}) / den,
// unsigned, low 32 quotient bits returned. den must be below 2^63.
// ----------------------------------------------------------------------------
`default_nettype none

module amq_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);
  import amq_pkg::*;

  logic [63:0] rem_q, rem_d;
  logic [63:0] dv_q, dv_d;
  logic [63:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [63:0] trial;
  logic [64:0] diff;
  logic        ge;

  assign trial = {rem_q[62:0], dv_q[63]};
  assign diff  = {1'b0, trial} - {1'b0, den_q};
  assign ge    = ~diff[64];

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      dv_d  = {num_i, 32'd0};
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[63:0] : trial;
      dv_d  = {dv_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = dv_q[31:0];

endmodule

`default_nettype wire

FILE: sv/affine_matrix_engine_q16_unit.sv
// ----------------------------------------------------------------------------
// affine_matrix_engine_q16_unit
// Holds one 2D affine matrix in signed 16.16 and applies one command per
// transfer: concatenate matrix or translation, transform point, identity,
// invert. One shared 32x32 multiplier and a bit-serial divider.
//
// channel   direction  signals
// command   in         start, busy, kind_i, m_*_i, pt_x_i, pt_y_i
// result    out        out_valid_o, out_x_o, out_y_o
//
// Each product goes through a multiply step and then a round-and-add step
// on the shared multiplier. Invert computes the determinant, then runs
// four divisions on the bit-serial divider; a zero determinant loads
// identity instead.
// Identity and unused kinds finish at the accepting edge.
// Reset restores identity. The receiver cannot stall; busy holds off start.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_matrix_engine_q16_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] m_a_i,
  input  wire logic [31:0] m_b_i,
  input  wire logic [31:0] m_c_i,
  input  wire logic [31:0] m_d_i,
  input  wire logic [31:0] m_tx_i,
  input  wire logic [31:0] m_ty_i,
  input  wire logic [31:0] pt_x_i,
  input  wire logic [31:0] pt_y_i,
  output logic             out_valid_o,
  output logic [31:0]      out_x_o,
  output logic [31:0]      out_y_o
);
  import amq_pkg::*;

  state_e             state_q;
  logic [2:0]         kind_q;
  logic [31:0]        mat_q [0:5];
  logic [31:0]        n_q   [0:5];
  logic [31:0]        iu_q  [0:2];
  logic [31:0]        iv_q  [0:2];
  logic [2:0]         e_q;
  logic               t_q;
  logic               neg_q;
  logic [31:0]        acc_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] det_q;
  logic [1:0]         qi_q;
  logic               qneg_q;
  logic               valid_q;
  logic [31:0]        ox_q, oy_q;

  logic               accept;
  logic signed [31:0] opx, opy;
  logic signed [63:0] prod_d;
  logic [47:0]        rnd_full;
  logic [31:0]        sum;
  logic [31:0]        base;
  logic signed [63:0] det_next;
  logic [31:0]        dv_src;
  logic [31:0]        num_mag;
  logic               num_neg;
  logic [63:0]        den_mag;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    opx = $signed(mat_q[{1'b0, t_q, e_q[0]}]);
    opy = t_q ? $signed(iv_q[e_q[2:1]]) : $signed(iu_q[e_q[2:1]]);
    case (state_q)
      S_DET1:  begin
        opx = $signed(mat_q[IDX_A]);
        opy = $signed(mat_q[IDX_D]);
      end
      S_DET2:  begin
        opx = $signed(mat_q[IDX_B]);
        opy = $signed(mat_q[IDX_C]);
      end
      default: ;
    endcase
  end

  assign prod_d   = opx * opy;
  assign rnd_full = prod_q[47:0] + RND_Q16;
  assign sum      = acc_q + rnd_full[47:16];
  assign det_next = det_q - prod_q;

  always_comb begin
    base = '0;
    if (!neg_q) begin
      if (e_q == IDX_TX) begin
        base = mat_q[IDX_TX];
      end else if (e_q == IDX_TY) begin
        base = mat_q[IDX_TY];
      end
    end
  end

  always_comb begin
    case (qi_q)
      2'd0:    dv_src = mat_q[IDX_D];
      2'd1:    dv_src = mat_q[IDX_B];
      2'd2:    dv_src = mat_q[IDX_C];
      default: dv_src = mat_q[IDX_A];
    endcase
    num_mag   = dv_src[31] ? (32'd0 - dv_src) : dv_src;
    num_neg   = dv_src[31] ^ ((qi_q == 2'd1) || (qi_q == 2'd2));
    den_mag   = det_q[63] ? (64'd0 - det_q) : det_q;
    div_start = (state_q == S_DIVS);
  end

  amq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      kind_q         <= '0;
      e_q            <= '0;
      t_q            <= 1'b0;
      neg_q          <= 1'b0;
      qi_q           <= '0;
      valid_q        <= 1'b0;
      mat_q[IDX_A]   <= ONE_Q16;
      mat_q[IDX_B]   <= '0;
      mat_q[IDX_C]   <= '0;
      mat_q[IDX_D]   <= ONE_Q16;
      mat_q[IDX_TX]  <= '0;
      mat_q[IDX_TY]  <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q <= kind_i;
            neg_q  <= 1'b0;
            t_q    <= 1'b0;
            case (kind_i)
              K_CAT_MAT: begin
                e_q     <= IDX_A;
                state_q <= S_MUL;
              end
              K_CAT_TRANS, K_XFORM: begin
                e_q     <= IDX_TX;
                state_q <= S_MUL;
              end
              K_IDENT: begin
                mat_q[IDX_A]  <= ONE_Q16;
                mat_q[IDX_B]  <= '0;
                mat_q[IDX_C]  <= '0;
                mat_q[IDX_D]  <= ONE_Q16;
                mat_q[IDX_TX] <= '0;
                mat_q[IDX_TY] <= '0;
              end
              K_INVERT: begin
                qi_q    <= '0;
                state_q <= S_DET1;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (!t_q) begin
            t_q     <= 1'b1;
            state_q <= S_MUL;
          end else if (e_q == IDX_TY) begin
            state_q <= S_COMMIT;
          end else begin
            e_q     <= e_q + 3'd1;
            t_q     <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_COMMIT: begin
          state_q <= S_IDLE;
          case (kind_q)
            K_CAT_MAT: begin
              for (int i = 0; i < 6; i++) begin
                mat_q[i] <= n_q[i];
              end
            end
            K_CAT_TRANS, K_INVERT: begin
              mat_q[IDX_TX] <= n_q[IDX_TX];
              mat_q[IDX_TY] <= n_q[IDX_TY];
            end
            K_XFORM: begin
              valid_q <= 1'b1;
            end
            default: ;
          endcase
        end
        S_DET1: begin
          state_q <= S_DET2;
        end
        S_DET2: begin
          state_q <= S_DET3;
        end
        S_DET3: begin
          if (det_next == 64'sd0) begin
            mat_q[IDX_A]  <= ONE_Q16;
            mat_q[IDX_B]  <= '0;
            mat_q[IDX_C]  <= '0;
            mat_q[IDX_D]  <= ONE_Q16;
            mat_q[IDX_TX] <= '0;
            mat_q[IDX_TY] <= '0;
            state_q       <= S_IDLE;
          end else begin
            state_q <= S_DIVS;
          end
        end
        S_DIVS: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            qi_q <= qi_q + 2'd1;
            if (qi_q == 2'd3) begin
              state_q <= S_COPY;
            end else begin
              state_q <= S_DIVS;
            end
          end
        end
        S_COPY: begin
          mat_q[IDX_A] <= n_q[IDX_A];
          mat_q[IDX_B] <= n_q[IDX_B];
          mat_q[IDX_C] <= n_q[IDX_C];
          mat_q[IDX_D] <= n_q[IDX_D];
          e_q          <= IDX_TX;
          t_q          <= 1'b0;
          neg_q        <= 1'b1;
          state_q      <= S_MUL;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      iu_q[0] <= m_a_i;
      iv_q[0] <= m_b_i;
      iu_q[1] <= m_c_i;
      iv_q[1] <= m_d_i;
      iu_q[2] <= (kind_i == K_XFORM) ? pt_x_i : m_tx_i;
      iv_q[2] <= (kind_i == K_XFORM) ? pt_y_i : m_ty_i;
    end
    if (state_q == S_COPY) begin
      iu_q[2] <= mat_q[IDX_TX];
      iv_q[2] <= mat_q[IDX_TY];
    end
    if (state_q == S_MUL || state_q == S_DET1 || state_q == S_DET2) begin
      prod_q <= prod_d;
    end
    if (state_q == S_MUL && !t_q) begin
      acc_q <= base;
    end
    if (state_q == S_ADD) begin
      if (!t_q) begin
        acc_q <= sum;
      end else begin
        n_q[e_q] <= neg_q ? (32'd0 - sum) : sum;
      end
    end
    if (state_q == S_DET2) begin
      det_q <= prod_q;
    end
    if (state_q == S_DET3) begin
      det_q <= det_next;
    end
    if (state_q == S_DIVS) begin
      qneg_q <= num_neg ^ det_q[63];
    end
    if (state_q == S_DIVW && div_done) begin
      n_q[{1'b0, qi_q}] <= qneg_q ? (32'd0 - div_quo) : div_quo;
    end
    if (state_q == S_COMMIT) begin
      ox_q <= n_q[IDX_TX];
      oy_q <= n_q[IDX_TY];
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;

  a_strobe_from_xform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == S_COMMIT && kind_q == K_XFORM))
    else $error("result strobe without transform commit");

  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == K_CAT_MAT || kind_i == K_CAT_TRANS ||
                kind_i == K_XFORM || kind_i == K_INVERT)) |=> busy)
    else $error("working command did not raise busy");

  a_idle_holds_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start) |=>
      ($stable(mat_q[IDX_A]) && $stable(mat_q[IDX_TX])))
    else $error("matrix changed while idle");

  a_no_strobe_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("result strobe while busy");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command transfers into affine_matrix_engine_q16_unit, tracks the
// matrix state in a local 16.16 model and checks every transformed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import amq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind_i = '0;
  logic [31:0] m_a_i = '0, m_b_i = '0, m_c_i = '0, m_d_i = '0;
  logic [31:0] m_tx_i = '0, m_ty_i = '0, pt_x_i = '0, pt_y_i = '0;
  logic        out_valid_o;
  logic [31:0] out_x_o, out_y_o;

  logic [31:0] st_a, st_b, st_c, st_d, st_tx, st_ty;
  logic [63:0] pending_pts[$];
  int          n_err = 0;
  int          idle_pct = 0;

  always #1 clk_i = ~clk_i;

  affine_matrix_engine_q16_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i,
    .m_a_i, .m_b_i, .m_c_i, .m_d_i, .m_tx_i, .m_ty_i, .pt_x_i, .pt_y_i,
    .out_valid_o, .out_x_o, .out_y_o
  );

  function automatic logic [31:0] qmul(logic [31:0] x, logic [31:0] y);
    logic signed [63:0] p;
    logic [63:0] u;
    p = $signed({{32{x[31]}}, x}) * $signed({{32{y[31]}}, y});
    u = p + 64'h8000;
    return u[47:16];
  endfunction

  function automatic logic [31:0] qdiv(logic signed [63:0] v, logic signed [63:0] den);
    logic neg;
    logic [63:0] mv, md;
    logic [95:0] q;
    neg = v[63] ^ den[63];
    mv = v[63] ? -v : v;
    md = den[63] ? -den : den;
    q = {mv, 32'b0} / {32'b0, md};
    if (neg) q = -q;
    return q[31:0];
  endfunction

  task automatic load_ident();
    st_a = ONE_Q16; st_b = '0; st_c = '0; st_d = ONE_Q16; st_tx = '0; st_ty = '0;
  endtask

  task automatic predict(logic [2:0] k, logic [31:0] a, b, c, d, tx, ty, px, py);
    logic [31:0] na, nb, nc, nd, ntx, nty;
    logic signed [63:0] det, sa, sb, sc, sd;
    case (k)
      K_CAT_MAT: begin
        na = qmul(st_a, a) + qmul(st_c, b);
        nb = qmul(st_b, a) + qmul(st_d, b);
        nc = qmul(st_a, c) + qmul(st_c, d);
        nd = qmul(st_b, c) + qmul(st_d, d);
        ntx = qmul(st_a, tx) + qmul(st_c, ty) + st_tx;
        nty = qmul(st_b, tx) + qmul(st_d, ty) + st_ty;
        st_a = na; st_b = nb; st_c = nc; st_d = nd; st_tx = ntx; st_ty = nty;
      end
      K_CAT_TRANS: begin
        ntx = st_tx + qmul(st_a, tx) + qmul(st_c, ty);
        nty = st_ty + qmul(st_b, tx) + qmul(st_d, ty);
        st_tx = ntx; st_ty = nty;
      end
      K_XFORM: pending_pts.push_back({qmul(st_a, px) + qmul(st_c, py) + st_tx,
                                      qmul(st_b, px) + qmul(st_d, py) + st_ty});
      K_IDENT: load_ident();
      K_INVERT: begin
        sa = {{32{st_a[31]}}, st_a}; sb = {{32{st_b[31]}}, st_b};
        sc = {{32{st_c[31]}}, st_c}; sd = {{32{st_d[31]}}, st_d};
        det = sa * sd - sb * sc;
        if (det == 0) begin
          load_ident();
        end else begin
          na = qdiv(sd, det); nd = qdiv(sa, det);
          nc = qdiv(-sc, det); nb = qdiv(-sb, det);
          ntx = 32'd0 - (qmul(st_tx, na) + qmul(st_ty, nc));
          nty = 32'd0 - (qmul(st_tx, nb) + qmul(st_ty, nd));
          st_a = na; st_b = nb; st_c = nc; st_d = nd; st_tx = ntx; st_ty = nty;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(logic [2:0] k, logic [31:0] a, b, c, d, tx, ty, px, py);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    kind_i = k; m_a_i = a; m_b_i = b; m_c_i = c; m_d_i = d;
    m_tx_i = tx; m_ty_i = ty; pt_x_i = px; pt_y_i = py;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict(k, a, b, c, d, tx, ty, px, py);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o) begin
      if (pending_pts.size() == 0) begin
        $display("%0t unexpected result x=%h y=%h", $time, out_x_o, out_y_o);
        n_err++;
      end else begin
        logic [63:0] e;
        e = pending_pts.pop_front();
        if (out_x_o !== e[63:32]) begin
          $display("%0t out_x exp %h got %h", $time, e[63:32], out_x_o);
          n_err++;
        end
        if (out_y_o !== e[31:0]) begin
          $display("%0t out_y exp %h got %h", $time, e[31:0], out_y_o);
          n_err++;
        end
      end
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {15'd0, 1'($urandom_range(1)), 16'($urandom_range(65535))};
      2: return -$urandom_range(131072);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $signed($urandom_range(262144)) - 131072;
    endcase
  endfunction

  task automatic xform_rnd();
    send_cmd(K_XFORM, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), rnd_val(), rnd_val());
  endtask

  task automatic test_directed();
    xform_rnd();
    send_cmd(K_XFORM, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
    send_cmd(K_CAT_MAT, 32'h0002_0000, 32'h0000_8000, 32'hffff_0000, 32'h0001_8000,
             32'h0003_0000, 32'hfffe_0000, 0, 0);
    xform_rnd();
    send_cmd(K_CAT_TRANS, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    xform_rnd();
    send_cmd(K_INVERT, $urandom(), $urandom(), $urandom(), $urandom(), 0, 0, 0, 0);
    xform_rnd();
    send_cmd(K_CAT_MAT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 0, 0);
    send_cmd(K_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    xform_rnd();
    send_cmd(K_CAT_MAT, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
             32'h7fff_ffff, 32'hffff_ffff, 0, 0);
    send_cmd(K_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    xform_rnd();
    for (int k = 5; k < 8; k++) send_cmd(k[2:0], $urandom(), $urandom(), $urandom(),
                                         $urandom(), $urandom(), $urandom(),
                                         $urandom(), $urandom());
    xform_rnd();
    send_cmd(K_IDENT, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom());
    xform_rnd();
  endtask

  task automatic test_random(int n);
    logic [2:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2: k = K_CAT_MAT;
        3, 4: k = K_CAT_TRANS;
        5: k = K_IDENT;
        6: k = K_INVERT;
        7: k = 3'($urandom_range(7, 5));
        default: k = K_XFORM;
      endcase
      send_cmd(k, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
               rnd_val(), rnd_val());
    end
  endtask

  initial begin
    load_ident();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    idle_pct = 0;  test_random(100);
    idle_pct = 87; test_random(100);
    idle_pct = 32; test_random(100);
    idle_pct = 0;  test_random(100);
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (n_err == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end
endmodule
